/* rtl/core/zrsc_pkg.sv */
// ----------------------------------------------------------------------------
// Zero-run sector compressor package
// Shared constants and types for the compressor core and its submodules.
// ----------------------------------------------------------------------------
package zrsc_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int IDX_W        = $clog2(SECTOR_BYTES);
    localparam int CNT_W        = $clog2(SECTOR_BYTES) + 1;
    localparam int LEN_W        = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH) + 1;

    localparam logic [7:0] ZERO_MARKER = 8'h00;
    localparam logic [7:0] RUN_CLOSE   = 8'hFF;
    localparam logic [7:0] RUN_MAX     = 8'd255;

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0]       code_byte;
        logic             is_last;
        logic             failed;
        logic [LEN_W-1:0] code_length;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

/* rtl/core/zrsc_encoder.sv */
// ----------------------------------------------------------------------------
// Zero-run sector compressor encoder
// Input register, sector state and the single-pass encode of one byte into
// up to two code results per transaction.
// ----------------------------------------------------------------------------
module zrsc_encoder
    import zrsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    output logic       o_in_ready,
    input  logic       i_room,
    output t_push      o_push
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [7:0]       r_run;
    logic [CNT_W-1:0] r_out_count;
    logic [IDX_W-1:0] r_index;
    logic             r_aborted;

    logic             w_fire;
    logic             w_last;
    logic [7:0]       n_run;
    logic [1:0]       w_cnt;
    logic [7:0]       w_buf [2];
    logic [CNT_W-1:0] w_total;
    logic             w_fail;

    assign w_fire     = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_last     = (r_index == IDX_W'(SECTOR_BYTES - 1));

    always_comb begin
        n_run    = r_run;
        w_cnt    = PUSH_NONE;
        w_buf[0] = ZERO_MARKER;
        w_buf[1] = ZERO_MARKER;
        if (r_in_byte == 8'd0) begin
            if (r_run == 8'd0) begin
                w_buf[0] = ZERO_MARKER;
                w_cnt    = PUSH_ONE;
                n_run    = 8'd1;
            end else if (r_run >= RUN_MAX) begin
                w_buf[0] = RUN_CLOSE;
                w_cnt    = PUSH_ONE;
                n_run    = 8'd0;
            end else begin
                n_run = r_run + 8'd1;
            end
        end else begin
            if (r_run != 8'd0) begin
                w_buf[0] = r_run - 8'd1;
                w_buf[1] = r_in_byte;
                w_cnt    = PUSH_TWO;
            end else begin
                w_buf[0] = r_in_byte;
                w_cnt    = PUSH_ONE;
            end
            n_run = 8'd0;
        end
        if (w_last && (n_run != 8'd0) && (w_cnt != PUSH_TWO)) begin
            if (w_cnt == PUSH_NONE) begin
                w_buf[0] = n_run - 8'd1;
                w_cnt    = PUSH_ONE;
            end else begin
                w_buf[1] = n_run - 8'd1;
                w_cnt    = PUSH_TWO;
            end
            n_run = 8'd0;
        end
    end

    assign w_total = r_out_count + CNT_W'(w_cnt);
    assign w_fail  = (w_total >= CNT_W'(SECTOR_BYTES));

    always_comb begin
        o_push = '0;
        if (w_fire && !r_aborted) begin
            if (w_fail) begin
                o_push.count          = PUSH_ONE;
                o_push.res0.code_byte = 8'd0;
                o_push.res0.is_last   = 1'b1;
                o_push.res0.failed    = 1'b1;
            end else begin
                o_push.count          = w_cnt;
                o_push.res0.code_byte = w_buf[0];
                o_push.res1.code_byte = w_buf[1];
                if (w_last && (w_cnt == PUSH_ONE)) begin
                    o_push.res0.is_last     = 1'b1;
                    o_push.res0.code_length = w_total[LEN_W-1:0];
                end
                if (w_last && (w_cnt == PUSH_TWO)) begin
                    o_push.res1.is_last     = 1'b1;
                    o_push.res1.code_length = w_total[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_run       <= 8'd0;
            r_out_count <= '0;
            r_index     <= '0;
            r_aborted   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                if (w_last) begin
                    r_run       <= 8'd0;
                    r_out_count <= '0;
                    r_index     <= '0;
                    r_aborted   <= 1'b0;
                end else begin
                    r_index <= r_index + IDX_W'(1);
                    if (!r_aborted) begin
                        r_run <= n_run;
                        if (w_fail) begin
                            r_aborted <= 1'b1;
                        end else begin
                            r_out_count <= w_total;
                        end
                    end
                end
            end
        end
    end

endmodule

/* rtl/core/zrsc_out_queue.sv */
// ----------------------------------------------------------------------------
// Zero-run sector compressor result queue
// Small register queue that takes up to two results per cycle and hands out
// one result per transaction on the output channel.
// ----------------------------------------------------------------------------
module zrsc_out_queue
    import zrsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign o_room      = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_result    = r_mem[r_rd_ptr];
    assign w_pop       = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.count != PUSH_NONE) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == PUSH_TWO) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.res1;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push.count) - QCNT_W'(w_pop);
        end
    end

endmodule

/* rtl/core/zero_run_sector_compressor_core.sv */
// ----------------------------------------------------------------------------
// Zero-run sector compressor core
// Compresses the bytes of fixed-size sectors with zero-run-length coding.
// ----------------------------------------------------------------------------
// The input channel takes one raw sector byte per transaction; the block
// counts bytes itself, so a new sector starts right after the last byte of
// the previous one. The output channel gives one code byte per transaction,
// with is_last on the final result of a sector and code_length on that
// result unless it failed. When the code would reach the sector size, a
// single failure result closes the sector and its remaining input bytes are
// taken without output. A result is offered once its byte has passed the
// input register and the queue. An input byte is accepted in every cycle
// while the queue has room for two results, so the sustained rate is one
// byte per cycle for bytes with one result; bytes with two results are
// held back, as the output channel moves one result per cycle while the
// receiver is ready. When the receiver stalls, results wait in a four-entry
// queue and the input stops once fewer than two entries are free. Reset
// empties the queue and the input register and starts a new sector.
// ----------------------------------------------------------------------------
module zero_run_sector_compressor_core
    import zrsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_code_byte,
    output logic             o_is_last,
    output logic             o_failed,
    output logic [LEN_W-1:0] o_code_length
);

    t_push   w_push;
    logic    w_room;
    t_result w_result;

    zrsc_encoder u_encoder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .o_in_ready (o_in_ready),
        .i_room     (w_room),
        .o_push     (w_push)
    );

    zrsc_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_code_byte   = w_result.code_byte;
    assign o_is_last     = w_result.is_last;
    assign o_failed      = w_result.failed;
    assign o_code_length = w_result.code_length;

    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_failed) |-> o_is_last)
        else $error("Failure result without is_last.");

    a_len_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (!o_is_last || o_failed)) |-> (o_code_length == '0))
        else $error("Code length on a result that is not a good final one.");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count != PUSH_NONE) |-> w_room)
        else $error("Results pushed while the queue lacks room.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid right after reset.");

endmodule
